// ===== sv/bpc_pkg.sv =====
`timescale 1ns / 1ps
package bpc_pkg;

    // Restoring divider geometry, shared by both divisions
    localparam int DIV_STAGES = 32;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 20;
    localparam int SIDE_W     = 45;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;   // numerator bits shift out, quotient bits shift in
    } t_div_state;

    typedef enum logic [2:0] {
        CFG_AC1_AC2  = 3'd0,
        CFG_AC3_AC4  = 3'd1,
        CFG_AC5_AC6  = 3'd2,
        CFG_B1_B2    = 3'd3,
        CFG_MC_MD    = 3'd4,
        CFG_OSS      = 3'd5
    } t_cfg_reg;

endpackage

// ===== sv/bpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [bpc_pkg::NUM_W-1:0]   i_num,
    input  wire logic [bpc_pkg::DEN_W-1:0]   i_den,
    input  wire logic [bpc_pkg::SIDE_W-1:0]  i_side,
    output logic                             o_valid,
    output logic [bpc_pkg::NUM_W-1:0]        o_quo,
    output logic [bpc_pkg::DEN_W-1:0]        o_rem,
    output logic [bpc_pkg::SIDE_W-1:0]       o_side
);

    localparam int N = bpc_pkg::DIV_STAGES;

    // One quotient bit per stage
    function automatic bpc_pkg::t_div_state f_step(input bpc_pkg::t_div_state s,
                                                   input logic [bpc_pkg::DEN_W-1:0] d);
        logic [bpc_pkg::DEN_W:0] trial;
        bpc_pkg::t_div_state o;
        trial = {s.rem, s.nq[bpc_pkg::NUM_W-1]};
        o.nq  = {s.nq[bpc_pkg::NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            o.rem   = bpc_pkg::DEN_W'(trial - {1'b0, d});
            o.nq[0] = 1'b1;
        end else begin
            o.rem = trial[bpc_pkg::DEN_W-1:0];
        end
        return o;
    endfunction

    logic                        r_valid [N];
    bpc_pkg::t_div_state         r_st    [N];
    logic [bpc_pkg::DEN_W-1:0]   r_den   [N];
    logic [bpc_pkg::SIDE_W-1:0]  r_side  [N];
    bpc_pkg::t_div_state         n_st    [N];

    always_comb begin
        n_st[0] = f_step('{rem: '0, nq: i_num}, i_den);
        for (int k = 1; k < N; k++) begin
            n_st[k] = f_step(r_st[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_valid[k] <= 1'b0;
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < N; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0]   <= n_st[0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < N; k++) begin
                r_st[k]   <= n_st[k];
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_quo   = r_st[N-1].nq;
    assign o_rem   = r_st[N-1].rem;
    assign o_side  = r_side[N-1];

endmodule
`default_nettype wire

// ===== sv/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Barometric pressure compensation. Each request carries a raw 16-bit temperature
// word and a raw 24-bit pressure word; each result carries the compensated pressure
// in pascals (saturated to 0..262143) and an error flag that is set, with pressure
// forced to zero, when either division sees a zero divisor. Calibration words and
// the oversampling mode are written through the configuration channel, which is
// always ready; write it only while no request is in flight. The datapath is a
// 77-stage pipeline that takes one request every cycle: two 32-stage restoring
// dividers (one quotient bit per stage) set most of the latency, and the whole
// pipeline holds as one when the result side stalls.
module barometric_pressure_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [17:0] pressure_pa, [23:18] zero
    output logic [0:0]       m_axis_tuser,   // [0] calc_error
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic signed [28:0] B6_OFFSET  = 29'sd4000;
    localparam logic [15:0]        B7_SCALE   = 16'd50000;
    localparam logic [31:0]        M_OFFSET   = 32'd32768;
    localparam logic [11:0]        K_SQ       = 12'd3038;
    localparam logic [12:0]        K_LIN      = 13'd7357;
    localparam logic signed [47:0] K_BIAS     = 48'sd3791;
    localparam logic [17:0]        PA_MAX     = 18'h3FFFF;

    // ---------------- configuration ----------------
    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= 2'd1;
        end else if (i_cfg_valid) begin
            unique case (bpc_pkg::t_cfg_reg'(i_cfg_index))
                bpc_pkg::CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_data;
                bpc_pkg::CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_data;
                bpc_pkg::CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_data;
                bpc_pkg::CFG_B1_B2:   r_b1_b2   <= i_cfg_data;
                bpc_pkg::CFG_MC_MD:   r_mc_md   <= i_cfg_data;
                bpc_pkg::CFG_OSS:     r_oss     <= i_cfg_data[1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(r_ac1_ac2[31:16]);
    assign ac2 = $signed(r_ac1_ac2[15:0]);
    assign ac3 = $signed(r_ac3_ac4[31:16]);
    assign ac4 = r_ac3_ac4[15:0];
    assign ac5 = r_ac5_ac6[31:16];
    assign ac6 = r_ac5_ac6[15:0];
    assign b1  = $signed(r_b1_b2[31:16]);
    assign b2  = $signed(r_b1_b2[15:0]);
    assign mc  = $signed(r_mc_md[31:16]);
    assign md  = $signed(r_mc_md[15:0]);

    // The whole pipeline advances together; hold everything while a result waits.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 0: capture, apply mode shift ----------------
    logic        r0_v;
    logic [15:0] r0_ut;
    logic [23:0] r0_up;

    // ---------------- stage 1: (UT - AC6) * AC5 ----------------
    logic               r1_v;
    logic signed [33:0] r1_prod;
    logic [23:0]        r1_up;
    logic signed [16:0] s1_diff;

    assign s1_diff = $signed({1'b0, r0_ut}) - $signed({1'b0, ac6});

    // ---------------- stage 2: X1, divisor, MC * 2^11 ----------------
    logic               r2_v;
    logic signed [18:0] r2_x1;
    logic signed [19:0] r2_den;
    logic signed [26:0] r2_num;
    logic [23:0]        r2_up;
    logic signed [18:0] s2_x1;

    assign s2_x1 = r1_prod[33:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (adv) begin
            r0_v <= s_axis_tvalid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_ut   <= s_axis_tdata[15:0];
            r0_up   <= s_axis_tdata[39:16] >> (4'd8 - {2'b00, r_oss});
            r1_prod <= s1_diff * $signed({1'b0, ac5});
            r1_up   <= r0_up;
            r2_x1   <= s2_x1;
            r2_den  <= 20'(s2_x1) + 20'(md);
            r2_num  <= 27'(mc) <<< 11;
            r2_up   <= r1_up;
        end
    end

    // ---------------- divider 1: X2 = MC * 2^11 / (X1 + MD), toward zero ----------------
    logic [bpc_pkg::NUM_W-1:0]  d1_num;
    logic [bpc_pkg::DEN_W-1:0]  d1_den;
    logic [bpc_pkg::SIDE_W-1:0] d1_side_in, d1_side;
    logic                       d1_v;
    logic [bpc_pkg::NUM_W-1:0]  d1_q;
    logic [bpc_pkg::DEN_W-1:0]  d1_r;
    logic [26:0]                num_mag;

    assign num_mag    = r2_num[26] ? 27'(-r2_num) : 27'(r2_num);
    assign d1_num     = {5'b0, num_mag};
    assign d1_den     = r2_den[19] ? 20'(-r2_den) : 20'(r2_den);
    // side: [44:21] up, [20:2] X1, [1] quotient negative, [0] error
    assign d1_side_in = {r2_up, r2_x1, r2_num[26] ^ r2_den[19], r2_den == '0};

    bpc_div u_div_x2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r2_v),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  (d1_side_in),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_rem   (d1_r),
        .o_side  (d1_side)
    );

    // ---------------- stage 3: B6 ----------------
    logic signed [27:0] s3_q, s3_x2;
    logic signed [18:0] s3_x1;
    logic signed [28:0] s3_b6;

    assign s3_q  = $signed(d1_q[27:0]);
    assign s3_x2 = d1_side[1] ? -s3_q : s3_q;
    assign s3_x1 = $signed(d1_side[20:2]);
    assign s3_b6 = 29'(s3_x1) + 29'(s3_x2) - B6_OFFSET;

    logic               r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic signed [27:0] r3_b6;
    logic [23:0]        r3_up, r4_up, r5_up, r6_up;
    logic               r3_err, r4_err, r5_err, r6_err, r7_err, r8_err;

    // stage 4: B6^2 and the two linear B6 terms
    logic signed [55:0] r4_sq;
    logic signed [43:0] r4_ac2b6, r4_ac3b6;

    // stage 5: B2 * SQ and B1 * SQ
    logic signed [44:0] s5_sq;
    logic signed [60:0] r5_b2sq, r5_b1sq;
    logic signed [43:0] r5_ac2b6, r5_ac3b6;

    assign s5_sq = $signed({1'b0, r4_sq[55:12]});

    // stage 6: B3 and the B4 multiplicand, modulo 2^32 where only low bits survive
    logic [33:0] s6_x1a, s6_x2a, s6_ac1x4, s6_v, s6_vs;
    logic [33:0] s6_x1b, s6_x2b, s6_t;
    logic [31:0] r6_b3, r6_m;

    assign s6_x1a   = r5_b2sq[44:11];
    assign s6_x2a   = 34'(r5_ac2b6 >>> 11);
    assign s6_ac1x4 = 34'(ac1) << 2;
    assign s6_v     = s6_x1a + s6_x2a + s6_ac1x4;
    assign s6_vs    = (s6_v << r_oss) + 34'd2;
    assign s6_x1b   = 34'(r5_ac3b6 >>> 13);
    assign s6_x2b   = r5_b1sq[49:16];
    assign s6_t     = s6_x1b + s6_x2b + 34'd2;

    // stage 7: B4 and UP - B3
    logic [47:0] s7_b4p;
    logic [16:0] r7_b4;
    logic [31:0] r7_d;

    assign s7_b4p = ac4 * r6_m;

    // stage 8: B7
    logic [15:0] s8_scale;
    logic [47:0] s8_b7p;
    logic [31:0] r8_b7;
    logic [16:0] r8_b4;

    assign s8_scale = B7_SCALE >> r_oss;
    assign s8_b7p   = r7_d * s8_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (adv) begin
            r3_v <= d1_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_b6    <= s3_b6[27:0];
            r3_up    <= d1_side[44:21];
            r3_err   <= d1_side[0];
            r4_sq    <= r3_b6 * r3_b6;
            r4_ac2b6 <= ac2 * r3_b6;
            r4_ac3b6 <= ac3 * r3_b6;
            r4_up    <= r3_up;
            r4_err   <= r3_err;
            r5_b2sq  <= b2 * s5_sq;
            r5_b1sq  <= b1 * s5_sq;
            r5_ac2b6 <= r4_ac2b6;
            r5_ac3b6 <= r4_ac3b6;
            r5_up    <= r4_up;
            r5_err   <= r4_err;
            r6_b3    <= s6_vs[33:2];
            r6_m     <= s6_t[33:2] + M_OFFSET;
            r6_up    <= r5_up;
            r6_err   <= r5_err;
            r7_b4    <= s7_b4p[31:15];
            r7_d     <= {8'b0, r6_up} - r6_b3;
            r7_err   <= r6_err;
            r8_b7    <= s8_b7p[31:0];
            r8_b4    <= r7_b4;
            r8_err   <= r7_err || (r7_b4 == '0);
        end
    end

    // ---------------- divider 2: B7 / B4 ----------------
    logic [bpc_pkg::SIDE_W-1:0] d2_side_in, d2_side;
    logic                       d2_v;
    logic [bpc_pkg::NUM_W-1:0]  d2_q;
    logic [bpc_pkg::DEN_W-1:0]  d2_r;

    // side: [18:2] B4, [1] B7 top bit, [0] error
    assign d2_side_in = {26'b0, r8_b4, r8_b7[31], r8_err};

    bpc_div u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r8_v),
        .i_num   (r8_b7),
        .i_den   ({3'b0, r8_b4}),
        .i_side  (d2_side_in),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_rem   (d2_r),
        .o_side  (d2_side)
    );

    // ---------------- stage 9: p, rounding in the extra half bit ----------------
    logic        s9_up;
    logic [32:0] r9_p;

    // floor(2*B7/B4) = 2q + (2r >= B4); above 2^31 the published form drops that bit
    assign s9_up = !d2_side[1] && ({d2_r[16:0], 1'b0} >= {1'b0, d2_side[18:2]});

    logic r9_v, r10_v, r11_v;
    logic r9_err, r10_err, r11_err;

    // stage 10
    logic [24:0] s10_ps;
    logic [49:0] r10_sqp;
    logic [45:0] r10_m2;
    logic [32:0] r10_p, r11_p;

    assign s10_ps = r9_p[32:8];

    // stage 11
    logic [61:0]        s11_x1p;
    logic signed [46:0] s11_neg;
    logic [45:0]        r11_x1;
    logic signed [30:0] r11_x2;

    assign s11_x1p = r10_sqp * K_SQ;
    assign s11_neg = -$signed({1'b0, r10_m2});

    // stage 12: final correction, saturation, and zeroing on error
    logic signed [47:0] s12_t;
    logic signed [49:0] s12_pf;
    logic [17:0]        s12_pa;

    assign s12_t  = $signed({2'b0, r11_x1}) + 48'(r11_x2) + K_BIAS;
    assign s12_pf = $signed({17'b0, r11_p}) + 50'(s12_t >>> 4);

    always_comb begin
        priority if (r11_err || s12_pf[49]) begin
            s12_pa = '0;
        end else if (s12_pf > $signed({32'b0, PA_MAX})) begin
            s12_pa = PA_MAX;
        end else begin
            s12_pa = s12_pf[17:0];
        end
    end

    logic        r12_v;
    logic [17:0] r12_pa;
    logic        r12_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (adv) begin
            r9_v  <= d2_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_p    <= {d2_q, 1'b0} + {32'b0, s9_up};
            r9_err  <= d2_side[0];
            r10_sqp <= s10_ps * s10_ps;
            r10_m2  <= r9_p * K_LIN;
            r10_p   <= r9_p;
            r10_err <= r9_err;
            r11_x1  <= s11_x1p[61:16];
            r11_x2  <= s11_neg[46:16];
            r11_p   <= r10_p;
            r11_err <= r10_err;
            r12_pa  <= s12_pa;
            r12_err <= r11_err;
        end
    end

    assign m_axis_tvalid = r12_v;
    assign m_axis_tdata  = {6'b0, r12_pa};
    assign m_axis_tuser  = r12_err;

endmodule
`default_nettype wire
